[rtl/sync_length_xor_frame_parser_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the sync/length/XOR frame parser
// Concurrent checks compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_XOR_FRAME_PARSER_ASSERT_SVH
`define SYNC_LENGTH_XOR_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define SLXFP_ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SLXFP_ASSERT(label, prop, msg) \
  `SLXFP_ASSERT_CLK(label, clk, rst, prop, msg)
`else
`define SLXFP_ASSERT_CLK(label, clock, reset, prop, msg)
`define SLXFP_ASSERT(label, prop, msg)
`endif

`endif

[rtl/slxfp_pkg.sv]
// ---------------------------------------------------------------------------
// slxfp_pkg
// Shared types, codes and reset values of the frame parser.
// ---------------------------------------------------------------------------
package slxfp_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_LEN     = 2'd2
  } reg_idx_t;

  localparam logic [7:0]  SyncFirstReset  = 8'hA5;
  localparam logic [7:0]  SyncSecondReset = 8'h5A;
  localparam logic [15:0] MaxLenReset     = 16'd600;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic {
    ERR_LENGTH = 1'b0,
    ERR_CHECK  = 1'b1
  } err_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] position;
    logic [7:0]  command;
    logic [15:0] frame_length;
    err_t        error_code;
  } result_t;

endpackage

[rtl/sync_length_xor_frame_parser.sv]
// ---------------------------------------------------------------------------
// sync_length_xor_frame_parser
// Deframes sync/command/length/payload/XOR-check frames from a byte stream.
// ---------------------------------------------------------------------------
// Takes one byte per cycle with no bubbles unless the result side stalls.
// Each byte passes through an input register, combinational state machine
// logic and a result register, loaded when its byte is processed. A stall on
// the result side holds the result register and then stalls the input once the
// input register is full. At most one result per byte: payload bytes with their
// index, and at the check byte a good-frame or checksum-error report; an
// oversized length reports an error right after the high length byte.
module sync_length_xor_frame_parser
  import slxfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [1:0]           kind,
  output logic [7:0]           data_byte,
  output logic [15:0]          position,
  output logic [7:0]           command,
  output logic [15:0]          frame_length,
  output logic                 error_code,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t    cfg;
  result_t res;
  logic    res_hit;
  logic    adv;
  logic    out_free;

  slxfp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slxfp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .out_free (out_free),
    .adv      (adv),
    .res_hit  (res_hit),
    .res      (res)
  );

  slxfp_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (adv & res_hit),
    .res          (res),
    .out_free     (out_free),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .position     (position),
    .command      (command),
    .frame_length (frame_length),
    .error_code   (error_code)
  );

`include "sync_length_xor_frame_parser_assert.svh"

  `SLXFP_ASSERT(a_check_err_kind,
    res_valid && error_code == ERR_CHECK |-> kind == KIND_ERROR,
    "checksum error code on non-error result")
  `SLXFP_ASSERT(a_nonpayload_zero,
    res_valid && kind != KIND_PAYLOAD |-> data_byte == 8'd0 && position == 16'd0,
    "payload fields set on frame report")
  `SLXFP_ASSERT(a_rise_from_adv,
    $rose(res_valid) |-> $past(adv),
    "result appeared without a processed byte")

endmodule

[rtl/slxfp_regs.sv]
// ---------------------------------------------------------------------------
// slxfp_regs
// APB register file: sync bytes and maximum payload length.
// ---------------------------------------------------------------------------
module slxfp_regs
  import slxfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first  <= SyncFirstReset;
      cfg.sync_second <= SyncSecondReset;
      cfg.max_len     <= MaxLenReset;
    end else if (wr_en) begin
      case (idx)
        REG_SYNC_FIRST:  cfg.sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: cfg.sync_second <= pwdata[7:0];
        REG_MAX_LEN:     cfg.max_len     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SYNC_FIRST:  prdata = {24'd0, cfg.sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, cfg.sync_second};
      REG_MAX_LEN:     prdata = {16'd0, cfg.max_len};
      default:         prdata = '0;
    endcase
  end

endmodule

[rtl/slxfp_core.sv]
// ---------------------------------------------------------------------------
// slxfp_core
// Input byte register and frame state machine; one byte per cycle unless the result register stalls.
// ---------------------------------------------------------------------------
module slxfp_core
  import slxfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  input  logic       out_free,
  output logic       adv,
  output logic       res_hit,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_CMD     = 3'd2,
    PH_LENLO   = 3'd3,
    PH_LENHI   = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  logic        byte_valid;
  logic [7:0]  byte_q;
  phase_t      phase, phase_next;
  logic [7:0]  held_command, held_command_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] byte_position, byte_position_next;
  logic [7:0]  running_check, running_check_next;
  logic [15:0] len_full;
  logic [15:0] pos_inc;

  assign adv      = byte_valid & out_free;
  assign rx_stall = byte_valid & ~out_free;
  assign len_full = {byte_q, held_length[7:0]};
  assign pos_inc  = byte_position + 16'd1;

  always_comb begin
    phase_next         = phase;
    held_command_next  = held_command;
    held_length_next   = held_length;
    byte_position_next = byte_position;
    running_check_next = running_check;
    res_hit            = 1'b0;
    res.kind           = KIND_PAYLOAD;
    res.data_byte      = 8'd0;
    res.position       = 16'd0;
    res.command        = held_command;
    res.frame_length   = held_length;
    res.error_code     = ERR_LENGTH;
    case (phase)
      PH_SYNC1: begin
        if (byte_q == cfg.sync_first) phase_next = PH_SYNC2;
      end
      PH_SYNC2: begin
        phase_next = (byte_q == cfg.sync_second) ? PH_CMD : PH_SYNC1;
      end
      PH_CMD: begin
        held_command_next  = byte_q;
        running_check_next = byte_q;
        phase_next         = PH_LENLO;
      end
      PH_LENLO: begin
        held_length_next   = {8'd0, byte_q};
        running_check_next = running_check ^ byte_q;
        phase_next         = PH_LENHI;
      end
      PH_LENHI: begin
        held_length_next   = len_full;
        running_check_next = running_check ^ byte_q;
        res.frame_length   = len_full;
        byte_position_next = 16'd0;
        if (len_full > cfg.max_len) begin
          res_hit    = 1'b1;
          res.kind   = KIND_ERROR;
          phase_next = PH_SYNC1;
        end else begin
          phase_next = (len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_hit            = 1'b1;
        res.data_byte      = byte_q;
        res.position       = byte_position;
        running_check_next = running_check ^ byte_q;
        byte_position_next = pos_inc;
        if (pos_inc >= held_length) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        res_hit = 1'b1;
        if (byte_q == running_check) begin
          res.kind = KIND_GOOD;
        end else begin
          res.kind       = KIND_ERROR;
          res.error_code = ERR_CHECK;
        end
        phase_next = PH_SYNC1;
      end
      default: begin
        phase_next = PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      phase      <= PH_SYNC1;
    end else begin
      if (rx_valid && !rx_stall) begin
        byte_valid <= 1'b1;
      end else if (adv) begin
        byte_valid <= 1'b0;
      end
      if (adv) phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) byte_q <= rx_byte;
    if (adv) begin
      held_command  <= held_command_next;
      held_length   <= held_length_next;
      byte_position <= byte_position_next;
      running_check <= running_check_next;
    end
  end

endmodule

[rtl/slxfp_out.sv]
// ---------------------------------------------------------------------------
// slxfp_out
// Result register between the state machine and the result channel.
// ---------------------------------------------------------------------------
module slxfp_out
  import slxfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     res,
  output logic        out_free,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] position,
  output logic [7:0]  command,
  output logic [15:0] frame_length,
  output logic        error_code
);

  result_t held;

  assign out_free     = ~res_valid | ~res_stall;
  assign kind         = held.kind;
  assign data_byte    = held.data_byte;
  assign position     = held.position;
  assign command      = held.command;
  assign frame_length = held.frame_length;
  assign error_code   = held.error_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= res;
  end

endmodule
